/* rtl/core/tpsc_pkg.sv */
// Shared types, register indexes and the waveform table of the sine commutator.
package tpsc_pkg;

   localparam int DUTY_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int ROM_DEPTH  = 360;
   localparam int ROM_IDX_W  = 9;
   localparam int ARG_IDX_W  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DELAY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION  = 1'b1;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
   } tpsc_result_type;

   // flattened sine, one full electrical turn
   localparam logic [DUTY_W-1:0] WAVE_ROM [0:ROM_DEPTH-1] = '{
      8'd128, 8'd132, 8'd136, 8'd140, 8'd143, 8'd147, 8'd151, 8'd155,
      8'd159, 8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd181, 8'd185,
      8'd189, 8'd192, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214,
      8'd218, 8'd221, 8'd225, 8'd228, 8'd232, 8'd235, 8'd238, 8'd239,
      8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
      8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252,
      8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
      8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248,
      8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241,
      8'd240, 8'd239, 8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243,
      8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd248, 8'd249, 8'd250,
      8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254,
      8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254,
      8'd254, 8'd254, 8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251,
      8'd250, 8'd250, 8'd249, 8'd248, 8'd248, 8'd247, 8'd246, 8'd245,
      8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239, 8'd238, 8'd235,
      8'd232, 8'd228, 8'd225, 8'd221, 8'd218, 8'd214, 8'd211, 8'd207,
      8'd203, 8'd200, 8'd196, 8'd192, 8'd189, 8'd185, 8'd181, 8'd178,
      8'd174, 8'd170, 8'd166, 8'd162, 8'd159, 8'd155, 8'd151, 8'd147,
      8'd143, 8'd140, 8'd136, 8'd132, 8'd128, 8'd124, 8'd120, 8'd116,
      8'd113, 8'd109, 8'd105, 8'd101, 8'd97,  8'd94,  8'd90,  8'd86,
      8'd82,  8'd78,  8'd75,  8'd71,  8'd67,  8'd64,  8'd60,  8'd56,
      8'd53,  8'd49,  8'd45,  8'd42,  8'd38,  8'd35,  8'd31,  8'd28,
      8'd24,  8'd21,  8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,
      8'd12,  8'd11,  8'd10,  8'd9,   8'd8,   8'd8,   8'd7,   8'd6,
      8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd2,
      8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,
      8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,
      8'd6,   8'd6,   8'd7,   8'd8,   8'd8,   8'd9,   8'd10,  8'd11,
      8'd12,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd17,
      8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd11,  8'd10,  8'd9,
      8'd8,   8'd8,   8'd7,   8'd6,   8'd6,   8'd5,   8'd4,   8'd4,
      8'd3,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,
      8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
      8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
      8'd16,  8'd17,  8'd18,  8'd21,  8'd24,  8'd28,  8'd31,  8'd35,
      8'd38,  8'd42,  8'd45,  8'd49,  8'd53,  8'd56,  8'd60,  8'd64,
      8'd67,  8'd71,  8'd75,  8'd78,  8'd82,  8'd86,  8'd90,  8'd94,
      8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd116, 8'd120, 8'd124
   };

   // indexes past the end of the table read as zero duty
   function automatic logic [DUTY_W-1:0] wave_lookup(input logic [ARG_IDX_W-1:0] idx);
      logic [DUTY_W-1:0] duty;
      if (idx >= ARG_IDX_W'(ROM_DEPTH)) begin
         duty = '0;
      end else begin
         duty = WAVE_ROM[idx[ROM_IDX_W-1:0]];
      end
      return duty;
   endfunction

endpackage

/* rtl/core/tpsc_step.sv */
// Step timing compare, phase index registers and table lookup.
module tpsc_step import tpsc_pkg::*; #(
   parameter int TABLE_LENGTH = 360,
   parameter int TIME_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [TIME_WIDTH-1:0] now_us,
   input  logic [CSR_DATA_W-1:0] step_delay,
   input  logic                  direction_ccw,
   output logic                  fire,
   output tpsc_result_type       result
);

   localparam int IDX_W = $clog2(TABLE_LENGTH);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_LENGTH - 1);
   localparam logic [IDX_W-1:0] IDX_RST_B = IDX_W'(TABLE_LENGTH / 3);
   localparam logic [IDX_W-1:0] IDX_RST_C = IDX_W'((TABLE_LENGTH / 3) * 2);

   logic [TIME_WIDTH-1:0] last_time_ff, last_time_in;
   logic [IDX_W-1:0]      idx_ff [3];
   logic [IDX_W-1:0]      idx_in [3];
   logic [TIME_WIDTH-1:0] elapsed;
   logic [TIME_WIDTH-1:0] delay_tw;

   assign delay_tw = TIME_WIDTH'(step_delay);
   assign elapsed  = now_us - last_time_ff;
   assign fire     = accept && (elapsed > delay_tw);

   assign result.duty_a = wave_lookup(ARG_IDX_W'(idx_ff[0]));
   assign result.duty_b = wave_lookup(ARG_IDX_W'(idx_ff[1]));
   assign result.duty_c = wave_lookup(ARG_IDX_W'(idx_ff[2]));

   always_comb begin
      last_time_in = fire ? now_us : last_time_ff;
      for (int i = 0; i < 3; i++) begin
         idx_in[i] = idx_ff[i];
         if (fire) begin
            if (direction_ccw) begin
               idx_in[i] = (idx_ff[i] == '0) ? IDX_LAST : idx_ff[i] - 1'b1;
            end else begin
               idx_in[i] = (idx_ff[i] == IDX_LAST) ? '0 : idx_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         idx_ff[0]    <= '0;
         idx_ff[1]    <= IDX_RST_B;
         idx_ff[2]    <= IDX_RST_C;
      end else begin
         last_time_ff <= last_time_in;
         for (int i = 0; i < 3; i++) begin
            idx_ff[i] <= idx_in[i];
         end
      end
   end

endmodule

/* rtl/core/three_phase_sine_commutator.sv */
// Top level of the three-phase sinusoidal commutator.
// Usage:
//   req channel: one timestamp word (req_now_us) per accepted word. When more
//     than step_delay_us has passed since the last step, a rsp word carries
//     three phase duties and every phase index advances one table slot.
//     Otherwise the word produces no response.
//   csr channel: index 0 = step delay (us), index 1 = direction (1 = ccw).
//     csr_ready is always high; write only while the block is idle.
// Responses are registered in out_ff, or in skid_ff while out_ff is held.
// Throughput: one word per cycle unless req_stall; step decision and state
//   update finish in the accept cycle, so back-to-back words need no bubbles.
// Reset: indices return to 0, 1/3 and 2/3 of the table, last step time to
//   zero, delay and direction to zero, output buffer empty.
// Stall: the output register is backed by a one-word skid register; req_stall
//   rises only when the skid holds a word, so no response is ever dropped.
module three_phase_sine_commutator import tpsc_pkg::*; #(
   parameter int TABLE_LENGTH = 360,
   parameter int TIME_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_WIDTH-1:0] req_now_us,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DUTY_W-1:0]     rsp_duty_a,
   output logic [DUTY_W-1:0]     rsp_duty_b,
   output logic [DUTY_W-1:0]     rsp_duty_c,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CSR_DATA_W-1:0] delay_ff, delay_in;
   logic                  dir_ff, dir_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  skid_vld_ff, skid_vld_in;
   tpsc_result_type       out_ff, out_in;
   tpsc_result_type       skid_ff, skid_in;
   tpsc_result_type       new_result;
   logic                  accept;
   logic                  fire;
   logic                  pop;

   assign csr_ready = 1'b1;
   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !skid_vld_ff;
   assign pop       = out_vld_ff && !rsp_stall;

   tpsc_step #(
      .TABLE_LENGTH (TABLE_LENGTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .now_us        (req_now_us),
      .step_delay    (delay_ff),
      .direction_ccw (dir_ff),
      .fire          (fire),
      .result        (new_result)
   );

   always_comb begin
      delay_in = delay_ff;
      dir_in   = dir_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_DELAY: delay_in = csr_data;
            CSR_DIRECTION:  dir_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // output register with a one-word skid behind it
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (fire) begin
         if (!out_vld_ff || pop) begin
            out_in     = new_result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = new_result;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= '0;
         dir_ff      <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         delay_ff    <= delay_in;
         dir_ff      <= dir_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_duty_a = out_ff.duty_a;
   assign rsp_duty_b = out_ff.duty_b;
   assign rsp_duty_c = out_ff.duty_c;

endmodule
